// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file tlfs_checker.sv
// no dependencies; included by files that hold concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is high
`define TLFS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define TLFS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tlfs_pkg.sv =====
// shared types and constants of the three-level feedback scheduler
// no dependencies; imported by the interfaces and every module
package tlfs_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 16;
  localparam int BURST_W       = 16;
  localparam int SLOT_W        = 4;
  localparam int LVL_W         = 2;
  localparam int QUANT_W       = 8;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;
  localparam int NUM_CLS       = 4;

  localparam logic [QUANT_W-1:0] QUANTUM_FIRST_RST  = 8'd2;
  localparam logic [QUANT_W-1:0] QUANTUM_SECOND_RST = 8'd4;

  localparam logic [LVL_W-1:0] LVL_TOP = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MID = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LOW = 2'd2;

  typedef enum logic {
    CMD_ADMIT = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ADMITTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_RAN      = 2'd2,
    ST_IDLE     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANTUM_FIRST  = 1'b0,
    CFG_QUANTUM_SECOND = 1'b1
  } cfg_reg_t;

  // candidate classes in pick priority order
  typedef enum logic [1:0] {
    CLS_L0     = 2'd0,
    CLS_L1     = 2'd1,
    CLS_L2_RUN = 2'd2,
    CLS_L2_NEW = 2'd3
  } cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_SEL,
    S_EXEC,
    S_FIN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic clear;
    logic sample;
    cls_t cls;
  } tlfs_pick_ctl_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [LVL_W-1:0]   run_level;
    logic               finished;
    logic [BURST_W-1:0] turnaround;
    logic [BURST_W-1:0] wait_time;
  } tlfs_res_t;

endpackage

// ===== rtl/core/tlfs_if.sv =====
// valid/ready channels of the scheduler: request and response
// depends on tlfs_pkg for field widths
interface tlfs_req_if import tlfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [BURST_W-1:0] burst;

  modport source (output valid, cmd, burst, input ready);
  modport sink (input valid, cmd, burst, output ready);
endinterface

interface tlfs_rsp_if import tlfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [SLOT_W-1:0]  slot;
  logic [LVL_W-1:0]   run_level;
  logic               finished;
  logic [BURST_W-1:0] turnaround;
  logic [BURST_W-1:0] wait_time;

  modport source (output valid, status, slot, run_level, finished, turnaround, wait_time,
                  input ready);
  modport sink (input valid, status, slot, run_level, finished, turnaround, wait_time,
                output ready);
endinterface

// ===== rtl/core/tlfs_pick.sv =====
// candidate tracker: keeps the best slot of each class while the table is scanned
// depends on tlfs_pkg
module tlfs_pick import tlfs_pkg::*; #(
  parameter int IDX_W = 4,
  parameter int KEY_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  tlfs_pick_ctl_t   ctl,
  input  logic [IDX_W-1:0] idx,
  input  logic [KEY_W-1:0] key,
  output logic             win_found,
  output logic [IDX_W-1:0] win_idx
);

  logic [NUM_CLS-1:0] has;
  logic [IDX_W-1:0]   bidx [NUM_CLS];
  logic [KEY_W-1:0]   bkey [NUM_CLS];
  logic               take;

  // strict compare in slot order keeps ties on the lowest slot
  assign take = ctl.sample && (!has[ctl.cls] || key < bkey[ctl.cls]);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      has <= '0;
    end else if (take) begin
      has[ctl.cls] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bidx[ctl.cls] <= idx;
      bkey[ctl.cls] <= key;
    end
  end

  always_comb begin
    win_found = 1'b0;
    win_idx   = '0;
    for (int c = NUM_CLS - 1; c >= 0; c--) begin
      if (has[c]) begin
        win_found = 1'b1;
        win_idx   = bidx[c];
      end
    end
  end

endmodule

// ===== rtl/core/three_level_feedback_scheduler.sv =====
// three-level feedback scheduler; one item at a time, result in an output register
// admit: one slot valid bit checked per cycle, from slot 0 up to the first free one or the last
// tick: the scan of the slot memory at one read a cycle, then drain and select states, and
// execute and finish states when a task runs; an idle tick goes from select to the result
// a new item can be taken in the cycle after its predecessor's result is loaded
// reset clears tick time, slot valid bits and control and restores the default quanta; slot memory is not cleared
module three_level_feedback_scheduler import tlfs_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  tlfs_req_if.sink              task_req,
  tlfs_rsp_if.source            task_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int KEY_W = (TIME_BITS > BURST_W) ? TIME_BITS : BURST_W;
  localparam int TA_W  = TIME_BITS + 1;
  localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [TA_W-1:0]      TA_LIM   = (TIME_BITS < BURST_W) ?
                                              TA_W'({TIME_BITS{1'b1}}) :
                                              TA_W'({BURST_W{1'b1}});

  typedef struct packed {
    logic [BURST_W-1:0]   remaining;
    logic [BURST_W-1:0]   original;
    logic [TIME_BITS-1:0] arrival;
    logic [LVL_W-1:0]     level;
    logic [BURST_W-1:0]   qleft;
  } rec_t;

  state_t               state, state_next;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_vld, rd_vld_next;
  logic                 cmd_q;
  logic [BURST_W-1:0]   burst_q;
  logic [TIME_BITS-1:0] tick_time;
  logic [SLOTS-1:0]     slot_valid;
  logic [QUANT_W-1:0]   quantum_first, quantum_second;
  logic [IDX_W-1:0]     win_q;
  logic [TA_W-1:0]      ta_q;
  logic [BURST_W-1:0]   orig_q;
  tlfs_res_t            pend;
  tlfs_res_t            out_res;
  logic                 out_valid;

  rec_t                 mem [SLOTS];
  rec_t                 mem_q;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  rec_t                 mem_wdata;

  tlfs_pick_ctl_t       pick_ctl;
  logic [KEY_W-1:0]     pick_key;
  logic                 win_found;
  logic [IDX_W-1:0]     win_idx;

  logic                 accept;
  logic                 out_free;
  logic                 cur_free;
  logic                 is_tick;

  // execute-stage arithmetic on the winner's record
  logic [BURST_W-1:0]   q_first_ext, q_second_ext;
  logic [BURST_W-1:0]   ql_start, ql_after, rem_after;
  logic                 done;
  logic [LVL_W-1:0]     lvl_after;
  logic [TA_W-1:0]      ta_diff;
  logic [TA_W-1:0]      ta_sat;
  logic [BURST_W-1:0]   tat, wt;

  assign accept    = task_req.valid && task_req.ready;
  assign task_req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || task_rsp.ready;
  assign cur_free  = !slot_valid[idx];
  assign is_tick   = (cmd_q == CMD_TICK);

  // slot memory; accesses never overlap since each item finishes its write-back first
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  tlfs_pick #(
    .IDX_W (IDX_W),
    .KEY_W (KEY_W)
  ) u_pick (
    .clk       (clk),
    .rst       (rst),
    .ctl       (pick_ctl),
    .idx       (rd_idx),
    .key       (pick_key),
    .win_found (win_found),
    .win_idx   (win_idx)
  );

  // classify the record coming back from the scan
  always_comb begin
    pick_ctl.clear  = accept;
    pick_ctl.sample = rd_vld && slot_valid[rd_idx] && (mem_q.level != 2'd3);
    pick_key        = KEY_W'(mem_q.remaining);
    case (mem_q.level)
      LVL_TOP: begin
        pick_ctl.cls = CLS_L0;
        pick_key     = KEY_W'(mem_q.arrival);
      end
      LVL_MID: begin
        pick_ctl.cls = CLS_L1;
        pick_key     = KEY_W'(mem_q.arrival);
      end
      default: begin
        pick_ctl.cls = (mem_q.qleft != '0) ? CLS_L2_RUN : CLS_L2_NEW;
      end
    endcase
  end

  always_comb begin
    q_first_ext  = (quantum_first == '0) ? BURST_W'(1) : BURST_W'(quantum_first);
    q_second_ext = (quantum_second == '0) ? BURST_W'(1) : BURST_W'(quantum_second);
    if (mem_q.qleft != '0) begin
      ql_start = mem_q.qleft;
    end else begin
      case (mem_q.level)
        LVL_TOP: ql_start = q_first_ext;
        LVL_MID: ql_start = q_second_ext;
        default: ql_start = (mem_q.remaining == '0) ? BURST_W'(1) : mem_q.remaining;
      endcase
    end
    ql_after  = ql_start - BURST_W'(1);
    rem_after = (mem_q.remaining != '0) ? mem_q.remaining - BURST_W'(1) : mem_q.remaining;
    done      = (rem_after == '0);
    lvl_after = (!done && ql_after == '0 && mem_q.level < LVL_LOW) ?
                mem_q.level + LVL_W'(1) : mem_q.level;
    ta_diff   = (tick_time >= mem_q.arrival) ?
                TA_W'(tick_time - mem_q.arrival) + TA_W'(1) : '0;
    ta_sat    = (ta_q > TA_LIM) ? TA_LIM : ta_q;
    tat       = BURST_W'(ta_sat);
    wt        = (tat > orig_q) ? tat - orig_q : '0;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN: begin
        if (!is_tick) begin
          if (cur_free || idx == LAST_IDX) state_next = S_RESULT;
        end else if (idx == LAST_IDX) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_SEL;
      S_SEL:    state_next = win_found ? S_EXEC : S_RESULT;
      S_EXEC:   state_next = S_FIN;
      S_FIN:    state_next = S_RESULT;
      S_RESULT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = idx;
    mem_wdata   = '0;
    mem_raddr   = idx;
    rd_vld_next = 1'b0;
    case (state)
      S_SCAN: begin
        if (is_tick) begin
          rd_vld_next = 1'b1;
        end else if (cur_free) begin
          mem_we              = 1'b1;
          mem_wdata.remaining = burst_q;
          mem_wdata.original  = burst_q;
          mem_wdata.arrival   = tick_time;
          mem_wdata.level     = LVL_TOP;
          mem_wdata.qleft     = '0;
        end
      end
      S_SEL: begin
        mem_raddr = win_idx;
      end
      S_EXEC: begin
        mem_we              = 1'b1;
        mem_waddr           = win_q;
        mem_wdata.remaining = rem_after;
        mem_wdata.original  = mem_q.original;
        mem_wdata.arrival   = mem_q.arrival;
        mem_wdata.level     = lvl_after;
        mem_wdata.qleft     = done ? '0 : ql_after;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rd_vld         <= 1'b0;
      tick_time      <= '0;
      slot_valid     <= '0;
      quantum_first  <= QUANTUM_FIRST_RST;
      quantum_second <= QUANTUM_SECOND_RST;
      out_valid      <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_vld_next;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_QUANTUM_FIRST:  quantum_first  <= cfg_data;
          CFG_QUANTUM_SECOND: quantum_second <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_SCAN && !is_tick && cur_free) begin
        slot_valid[idx] <= 1'b1;
      end
      if (state == S_EXEC && done) begin
        slot_valid[win_q] <= 1'b0;
      end
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
        if (is_tick && tick_time != TIME_MAX) begin
          tick_time <= tick_time + TIME_BITS'(1);
        end
      end else if (task_rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_idx <= idx;
    case (state)
      S_IDLE: begin
        idx     <= '0;
        cmd_q   <= task_req.cmd;
        burst_q <= (task_req.burst == '0) ? BURST_W'(1) : task_req.burst;
      end
      S_SCAN: begin
        if (!is_tick && cur_free) begin
          pend <= '{status: ST_ADMITTED, slot: SLOT_W'(idx), default: '0};
        end else if (!is_tick && idx == LAST_IDX) begin
          pend <= '{status: ST_REJECTED, default: '0};
        end else if (idx != LAST_IDX) begin
          idx <= idx + IDX_W'(1);
        end
      end
      S_SEL: begin
        win_q <= win_idx;
        pend  <= '{status: win_found ? ST_RAN : ST_IDLE,
                   slot: win_found ? SLOT_W'(win_idx) : '0,
                   default: '0};
      end
      S_EXEC: begin
        pend.run_level <= mem_q.level;
        pend.finished  <= done;
        ta_q           <= ta_diff;
        orig_q         <= mem_q.original;
      end
      S_FIN: begin
        if (pend.finished) begin
          pend.turnaround <= tat;
          pend.wait_time  <= wt;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_res <= pend;
        end
      end
      default: ;
    endcase
  end

  assign task_rsp.valid      = out_valid;
  assign task_rsp.status     = out_res.status;
  assign task_rsp.slot       = out_res.slot;
  assign task_rsp.run_level  = out_res.run_level;
  assign task_rsp.finished   = out_res.finished;
  assign task_rsp.turnaround = out_res.turnaround;
  assign task_rsp.wait_time  = out_res.wait_time;

endmodule

// ===== rtl/core/tlfs_checker.sv =====
// port-level checks of the scheduler, attached to the top level by bind
// depends on tlfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module tlfs_checker import tlfs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [1:0]         status,
  input logic               finished,
  input logic [BURST_W-1:0] turnaround,
  input logic [BURST_W-1:0] wait_time
);

  // a stalled response holds
  `TLFS_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(turnaround) && $stable(wait_time), "response changed while stalled")
  // one transaction in flight: no request taken right after one is accepted
  `TLFS_ASSERT(a_one_in_flight, clk, rst, req_valid && req_ready |=> !req_ready, "request taken while busy")
  // no response straight out of reset
  `TLFS_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !rsp_valid, "response valid after reset")
  // completion only reported for a task that ran, wait never above turnaround
  `TLFS_ASSERT(a_finish_sane, clk, rst, rsp_valid && finished |-> status == ST_RAN && wait_time <= turnaround, "inconsistent completion report")

endmodule

bind three_level_feedback_scheduler tlfs_checker u_tlfs_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (task_req.valid),
  .req_ready  (task_req.ready),
  .rsp_valid  (task_rsp.valid),
  .rsp_ready  (task_rsp.ready),
  .status     (task_rsp.status),
  .finished   (task_rsp.finished),
  .turnaround (task_rsp.turnaround),
  .wait_time  (task_rsp.wait_time)
);

// ===== tb/tb.sv =====
// self-checking bench for three_level_feedback_scheduler: admits, ticks, quantum settings, back-pressure, long bursts
// predicts every result with its own copy of the slot table; depends on tlfs_pkg and tlfs_if
module tb;
  import tlfs_pkg::*;

  localparam int unsigned TICK_CEIL   = (1 << TIME_BITS_DEF) - 1;
  localparam int unsigned TA_CEIL     = (TICK_CEIL < 65535) ? TICK_CEIL : 65535;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int          HOLD_CYCLES = 400;

  logic clk;
  logic rst;
  logic cfg_we;
  cfg_reg_t cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tlfs_req_if req_ch ();
  tlfs_rsp_if rsp_ch ();

  three_level_feedback_scheduler u_dut (
    .clk      (clk),
    .rst      (rst),
    .task_req (req_ch),
    .task_rsp (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // scheduler shadow state
  logic [QUANT_W-1:0] slice_top = QUANTUM_FIRST_RST;
  logic [QUANT_W-1:0] slice_mid = QUANTUM_SECOND_RST;
  int unsigned        sched_now = 0;
  bit [SLOTS_DEF-1:0] slot_busy = '0;
  int unsigned        left_units [SLOTS_DEF];
  int unsigned        burst_units [SLOTS_DEF];
  int unsigned        admit_tick [SLOTS_DEF];
  int unsigned        slice_units [SLOTS_DEF];
  logic [LVL_W-1:0]   slot_level [SLOTS_DEF];

  tlfs_res_t   due_results [$];
  tlfs_res_t   oldest_due;
  int          fail_count = 0;
  int unsigned cycle_count = 0;
  bit          send_jitter = 1;
  bit          drain_jitter = 1;
  bit          hold_req = 0;
  bit          hold_used = 0;
  int          hold_cnt = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("three_level_feedback_scheduler: mismatch");
      $finish;
    end
  end

  // response side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (drain_jitter && $urandom_range(99) < 13) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  function automatic int oldest_at(logic [LVL_W-1:0] lv);
    int best;
    best = -1;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      if (slot_busy[i] && slot_level[i] == lv &&
          (best < 0 || admit_tick[i] < admit_tick[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic int shortest_low(bit started);
    int best;
    best = -1;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      if (slot_busy[i] && slot_level[i] == LVL_LOW && ((slice_units[i] > 0) == started) &&
          (best < 0 || left_units[i] < left_units[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic tlfs_res_t schedule_step(cmd_t op, logic [BURST_W-1:0] len);
    tlfs_res_t   r;
    int          pick;
    int unsigned blen;
    int unsigned ta;
    int unsigned tat;
    logic [LVL_W-1:0] lv;
    r = '0;
    r.status = ST_ADMITTED;
    pick = -1;
    if (op == CMD_ADMIT) begin
      for (int i = 0; i < SLOTS_DEF; i++) begin
        if (!slot_busy[i] && pick < 0) pick = i;
      end
      if (pick < 0) begin
        r.status = ST_REJECTED;
      end else begin
        blen = (len == 0) ? 1 : len;
        slot_busy[pick] = 1'b1;
        left_units[pick] = blen;
        burst_units[pick] = blen;
        admit_tick[pick] = sched_now;
        slot_level[pick] = LVL_TOP;
        slice_units[pick] = 0;
        r.slot = pick[SLOT_W-1:0];
      end
      return r;
    end

    pick = oldest_at(LVL_TOP);
    if (pick < 0) pick = oldest_at(LVL_MID);
    if (pick < 0) pick = shortest_low(1'b1);
    if (pick < 0) pick = shortest_low(1'b0);

    if (pick < 0) begin
      r.status = ST_IDLE;
    end else begin
      lv = slot_level[pick];
      if (slice_units[pick] == 0) begin
        if (lv == LVL_TOP) slice_units[pick] = (slice_top == 0) ? 1 : slice_top;
        else if (lv == LVL_MID) slice_units[pick] = (slice_mid == 0) ? 1 : slice_mid;
        else slice_units[pick] = (left_units[pick] == 0) ? 1 : left_units[pick];
      end
      slice_units[pick]--;
      if (left_units[pick] > 0) left_units[pick]--;
      r.status = ST_RAN;
      r.slot = pick[SLOT_W-1:0];
      r.run_level = lv;
      if (left_units[pick] == 0) begin
        ta = sched_now + 1 - admit_tick[pick];
        tat = (ta > TA_CEIL) ? TA_CEIL : ta;
        r.finished = 1'b1;
        r.turnaround = tat[BURST_W-1:0];
        r.wait_time = (tat > burst_units[pick]) ? BURST_W'(tat - burst_units[pick]) : '0;
        slot_busy[pick] = 1'b0;
        slice_units[pick] = 0;
      end else if (slice_units[pick] == 0 && lv != LVL_LOW) begin
        slot_level[pick] = lv + 1'b1;
      end
    end
    if (sched_now < TICK_CEIL) sched_now++;
    return r;
  endfunction

  task automatic check_field(string fname, logic [BURST_W-1:0] want, logic [BURST_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("result with nothing expected: status %0d slot %0d", rsp_ch.status, rsp_ch.slot);
        fail_count++;
      end else begin
        oldest_due = due_results.pop_front();
        check_field("status", oldest_due.status, rsp_ch.status);
        check_field("slot", oldest_due.slot, rsp_ch.slot);
        check_field("run_level", oldest_due.run_level, rsp_ch.run_level);
        check_field("finished", oldest_due.finished, rsp_ch.finished);
        check_field("turnaround", oldest_due.turnaround, rsp_ch.turnaround);
        check_field("wait_time", oldest_due.wait_time, rsp_ch.wait_time);
      end
    end
  end

  // valid stays high after a transaction so back-to-back items go out without a gap
  task automatic send_item(cmd_t op, logic [BURST_W-1:0] len);
    if (send_jitter && $urandom_range(99) < 13) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= op;
    req_ch.burst <= len;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    due_results.push_back(schedule_step(op, len));
  endtask

  task automatic wait_results_done();
    req_ch.valid <= 1'b0;
    while (due_results.size() > 0) @(posedge clk);
  endtask

  task automatic write_quanta(logic [QUANT_W-1:0] top, logic [QUANT_W-1:0] mid);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_QUANTUM_FIRST;
    cfg_data <= top;
    @(posedge clk);
    cfg_idx <= CFG_QUANTUM_SECOND;
    cfg_data <= mid;
    @(posedge clk);
    cfg_we <= 1'b0;
    slice_top = top;
    slice_mid = mid;
  endtask

  function automatic logic [BURST_W-1:0] pick_burst();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return '0;
    if (roll < 70) return BURST_W'($urandom_range(1, 8));
    if (roll < 95) return BURST_W'($urandom_range(9, 40));
    return BURST_W'($urandom_range(41, 200));
  endfunction

  task automatic send_random_item();
    if ($urandom_range(99) < 16) send_item(CMD_ADMIT, pick_burst());
    else send_item(CMD_TICK, BURST_W'($urandom()));
  endtask

  task automatic test_directed();
    send_item(CMD_TICK, 16'h0000);       // nothing admitted yet
    send_item(CMD_ADMIT, 16'd0);         // zero burst runs as one
    send_item(CMD_ADMIT, 16'd3);
    repeat (4) send_item(CMD_TICK, 16'hFFFF);
    send_item(CMD_ADMIT, 16'd9);         // walks down all three levels
    repeat (7) send_item(CMD_TICK, 16'h0000);
    send_item(CMD_ADMIT, 16'd1);         // top level cuts into a started low slice
    repeat (3) send_item(CMD_TICK, 16'h5A5A);
    wait_results_done();
  endtask

  task automatic run_setting(logic [QUANT_W-1:0] top, logic [QUANT_W-1:0] mid, bit quiet,
                             int n);
    int done;
    int streak;
    done = 0;
    write_quanta(top, mid);
    send_jitter = !quiet;
    drain_jitter = !quiet;
    while (done < n) begin
      if ($urandom_range(99) < 4) begin
        // run of admits that can fill the table and get rejects
        streak = $urandom_range(6, 18);
        repeat (streak) send_item(CMD_ADMIT, pick_burst());
        done += streak;
      end else begin
        send_random_item();
        done++;
      end
    end
    wait_results_done();
    send_jitter = 1'b1;
    drain_jitter = 1'b1;
  endtask

  task automatic test_quantum_settings();
    run_setting(QUANTUM_FIRST_RST, QUANTUM_SECOND_RST, 1'b0, 170);
    run_setting(8'd1, 8'd1, 1'b0, 170);
    run_setting(8'd0, 8'd0, 1'b0, 170);     // zero quantum acts as one
    run_setting(8'd255, 8'd255, 1'b1, 170);
    run_setting(8'd3, 8'd7, 1'b0, 170);
    run_setting(QUANT_W'($urandom_range(1, 255)), QUANT_W'($urandom_range(1, 255)), 1'b0, 170);
  endtask

  task automatic test_backpressure();
    send_jitter = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_random_item();
    wait_results_done();
    send_jitter = 1'b1;
    repeat (10) send_random_item();
    wait_results_done();
    repeat (10) send_random_item();
    wait_results_done();
  endtask

  task automatic test_long_bursts();
    write_quanta(8'd255, 8'd1);
    send_jitter = 1'b0;
    drain_jitter = 1'b0;
    send_item(CMD_ADMIT, 16'hFFFF);
    send_item(CMD_ADMIT, 16'hAAAA);
    send_item(CMD_ADMIT, 16'h5555);
    // long top slice against a one-tick middle slice
    repeat (24) send_item(CMD_TICK, BURST_W'($urandom()));
    send_item(CMD_ADMIT, 16'd5);
    send_item(CMD_ADMIT, 16'd1);
    repeat (12) send_item(CMD_TICK, BURST_W'($urandom()));
    wait_results_done();
    send_jitter = 1'b1;
    drain_jitter = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_QUANTUM_FIRST;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.cmd <= CMD_ADMIT;
    req_ch.burst <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_quantum_settings();
    test_backpressure();
    test_long_bursts();

    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("three_level_feedback_scheduler: match");
    end else begin
      $display("three_level_feedback_scheduler: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tlfs_pkg.sv
rtl/core/tlfs_if.sv
rtl/core/tlfs_pick.sv
rtl/core/three_level_feedback_scheduler.sv
rtl/core/tlfs_checker.sv
tb/tb.sv
